>>> sv/fbte_pkg.sv
// Shared types, constants and symbol functions for the five-byte to text encoder.
package fbte_pkg;

  localparam int BlockBytes    = 5;
  localparam int SymPerBlock   = 8;
  localparam int QueueDepth    = 2;
  localparam int LetterCount   = 26;
  localparam int LetterBase    = 97;
  localparam int DigitBase     = 48;
  localparam int DigitOffset   = 48 - 26;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       run_last;
  } out_item_t;

  // One unit of work for the back end: an optional block and an optional pad digit.
  typedef struct packed {
    logic [39:0] blk;
    logic        has_block;
    logic        has_digit;
    logic [2:0]  pad;
  } job_t;

  typedef struct packed {
    logic [2:0] byte_count;
    logic       block_emitted;
  } fe_stat_t;

  typedef enum logic {
    BK_SYM,
    BK_DIG
  } back_state_t;

  function automatic logic [6:0] sym_to_char(input logic [4:0] s);
    logic [6:0] r;
    if (s < 5'(LetterCount)) begin
      r = 7'(s) + 7'(LetterBase);
    end else begin
      r = 7'(s) + 7'(DigitOffset);
    end
    return r;
  endfunction

  // Symbol k of a block: group k/2, odd-numbered bits for the first, even-numbered bits for the second.
  function automatic logic [4:0] block_symbol(input logic [39:0] blk, input logic [2:0] k);
    logic [9:0] grp;
    logic [4:0] s;
    case (k[2:1])
      2'd0: grp = blk[39:30];
      2'd1: grp = blk[29:20];
      2'd2: grp = blk[19:10];
      2'd3: grp = blk[9:0];
      default: grp = blk[9:0];
    endcase
    if (k[0]) begin
      s = {grp[8], grp[6], grp[4], grp[2], grp[0]};
    end else begin
      s = {grp[9], grp[7], grp[5], grp[3], grp[1]};
    end
    return s;
  endfunction

endpackage

>>> sv/fbte_front.sv
// Front end: accepts requests, collects bytes into blocks, pads and queues jobs.
module fbte_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  fbte_pkg::in_item_t  in_data,
  output logic                in_stall,
  input  logic                q_full,
  output logic                push,
  output fbte_pkg::job_t      push_job,
  output fbte_pkg::fe_stat_t  stat
);

  logic [39:0] buf_r, buf_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        emitted_r, emitted_nxt;

  logic        accept;
  logic [39:0] buf_upd;
  logic [2:0]  cnt_upd;
  logic        full;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    buf_upd = in_data.byte_present ? {buf_r[31:0], in_data.data_byte} : buf_r;
    cnt_upd = in_data.byte_present ? cnt_r + 3'd1 : cnt_r;
    full    = (cnt_upd == 3'(fbte_pkg::BlockBytes));

    push_job           = '0;
    push_job.blk       = buf_upd;
    push_job.has_block = full;
    cnt_nxt            = full ? 3'd0 : cnt_upd;
    emitted_nxt        = emitted_r | full;

    if (in_data.end_of_input) begin
      push_job.has_digit = emitted_r | full;
      if (!full && cnt_upd != 3'd0) begin
        // pad with 0x80 then zero bytes up to a full block
        push_job.has_block = 1'b1;
        push_job.has_digit = 1'b1;
        push_job.pad       = 3'(fbte_pkg::BlockBytes) - cnt_upd;
        case (cnt_upd)
          3'd1:    push_job.blk = {buf_upd[7:0], 8'h80, 24'h0};
          3'd2:    push_job.blk = {buf_upd[15:0], 8'h80, 16'h0};
          3'd3:    push_job.blk = {buf_upd[23:0], 8'h80, 8'h0};
          default: push_job.blk = {buf_upd[31:0], 8'h80};
        endcase
      end
      cnt_nxt     = 3'd0;
      emitted_nxt = 1'b0;
    end

    push = accept && (push_job.has_block || push_job.has_digit);
  end

  assign buf_nxt = buf_upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= 3'd0;
      emitted_r <= 1'b0;
    end else if (accept) begin
      cnt_r     <= cnt_nxt;
      emitted_r <= emitted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.byte_present) begin
      buf_r <= buf_nxt;
    end
  end

  assign stat.byte_count    = cnt_r;
  assign stat.block_emitted = emitted_r;

endmodule

>>> sv/fbte_fifo.sv
// Short job queue between the front and back ends.
module fbte_fifo #(
  parameter int DEPTH = fbte_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fbte_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output fbte_pkg::job_t head_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fbte_pkg::job_t  mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> sv/fbte_back.sv
// Back end: walks a job's eight symbols and its pad digit, each when present, into the output register.
module fbte_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  fbte_pkg::job_t      q_head,
  output logic                q_pop,
  output logic                out_valid,
  output fbte_pkg::out_item_t out_data,
  input  logic                out_stall
);

  localparam logic [2:0] SymLast = 3'(fbte_pkg::SymPerBlock - 1);

  fbte_pkg::back_state_t state_r, state_nxt;
  logic [2:0]            idx_r, idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  fbte_pkg::out_item_t   out_data_r, out_data_nxt;

  logic load;
  logic in_sym;

  assign load = q_valid && (!out_valid_r || !out_stall);

  // Outputs of the sequencer: the character and its last flag.
  always_comb begin
    in_sym = q_head.has_block && (state_r == fbte_pkg::BK_SYM);
    if (in_sym) begin
      out_data_nxt.out_char =
        fbte_pkg::sym_to_char(fbte_pkg::block_symbol(q_head.blk, idx_r));
      out_data_nxt.run_last = (idx_r == SymLast) && !q_head.has_digit;
    end else begin
      out_data_nxt.out_char = 7'(fbte_pkg::DigitBase) + {4'b0, q_head.pad};
      out_data_nxt.run_last = 1'b1;
    end
    q_pop = load && out_data_nxt.run_last;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    if (load) begin
      if (out_data_nxt.run_last) begin
        state_nxt = fbte_pkg::BK_SYM;
        idx_nxt   = 3'd0;
      end else if (idx_r == SymLast) begin
        state_nxt = fbte_pkg::BK_DIG;
        idx_nxt   = 3'd0;
      end else begin
        idx_nxt   = idx_r + 3'd1;
      end
    end
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fbte_pkg::BK_SYM;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/five_byte_to_text_encoder_unit.sv
// Top level of the five-byte to text encoder.
//
// Input channel (in_valid / in_stall / in_data): one request per cycle carries
// an optional byte (byte_present) and an end-of-stream flag (end_of_input).
// Bytes gather most significant first into a five-byte block; every full block
// turns into eight characters ('a'-'z', '0'-'5'). On end of stream a partial
// block is padded with 0x80 and zeros and encoded, then the pad-count digit
// follows if the stream emitted any block. A request that makes no character
// (a byte that does not close a block, an end of an empty stream) is dropped.
// Output channel (out_valid / out_stall / out_data): up to nine characters per
// request; run_last flags the last character caused by an input request.
// A request that makes a job writes it into the job queue as it is taken; with
// the back idle, the job's first character is then loaded from the queue head
// into the output register. Throughput: the front takes one request per cycle
// while the job queue has room; the back sequencer emits one character per
// cycle while the receiver does not stall. Receiver stall: the output register
// holds; the queue fills and then in_stall rises. Reset (rst_n low,
// synchronous) empties the queue, clears the byte count and the output valid
// flag; no clearing pass is needed.
module five_byte_to_text_encoder_unit #(
  parameter int QUEUE_DEPTH = fbte_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fbte_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fbte_pkg::out_item_t out_data
);

  logic               q_full;
  logic               push;
  fbte_pkg::job_t     push_job;
  fbte_pkg::fe_stat_t fe_stat;
  logic               q_valid;
  fbte_pkg::job_t     q_head;
  logic               q_pop;

  // Front: classify each request and queue the work it produces.
  fbte_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job),
    .stat     (fe_stat)
  );

  // Queue: decouple front and back so each side stalls on its own.
  fbte_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_job   (q_head)
  );

  // Back: serialize each job into characters.
  fbte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  // Bytes held never reach a full block; a full block is always flushed.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    fe_stat.byte_count < 3'(fbte_pkg::BlockBytes))
    else $error("byte count reached a full block");

  // Retiring a job leaves its last character in the output register.
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid && out_data.run_last))
    else $error("job retired without a last character");

  // Nothing is offered in the cycle after a reset edge.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

>>> sim/text_char_check_pkg.sv
// Scoreboard that predicts and checks the characters produced by the text encoder.
package text_char_check_pkg;
  import fbte_pkg::*;

  localparam logic [7:0] PadMarker = 8'h80;

  class text_char_scoreboard;
    logic [39:0] block_acc = '0;
    int unsigned bytes_held = 0;
    bit block_sent = 1'b0;
    out_item_t awaited_chars[$];
    int unsigned mismatches = 0;

    function logic [6:0] symbol_char(logic [4:0] sym);
      if (sym < 5'(LetterCount)) return 7'(LetterBase + int'(sym));
      return 7'(DigitBase + int'(sym) - LetterCount);
    endfunction

    function void queue_char(logic [6:0] code);
      out_item_t ch;
      ch.out_char = code;
      ch.run_last = 1'b0;
      awaited_chars.push_back(ch);
    endfunction

    // Split the block into four 10-bit groups, top first; odd-numbered bits then even-numbered bits.
    function void queue_block();
      logic [9:0] grp;
      logic [4:0] even_sym;
      logic [4:0] odd_sym;
      for (int g = 0; g < 4; g++) begin
        grp = block_acc[39 - 10 * g -: 10];
        for (int b = 0; b < 5; b++) begin
          even_sym[4 - b] = grp[9 - 2 * b];
          odd_sym[4 - b]  = grp[8 - 2 * b];
        end
        queue_char(symbol_char(even_sym));
        queue_char(symbol_char(odd_sym));
      end
      block_sent = 1'b1;
    endfunction

    function void note_request(in_item_t req);
      int unsigned first_new;
      int unsigned pad;
      first_new = awaited_chars.size();
      pad = 0;
      if (req.byte_present) begin
        block_acc = {block_acc[31:0], req.data_byte};
        bytes_held++;
        if (bytes_held == BlockBytes) begin
          queue_block();
          bytes_held = 0;
        end
      end
      if (req.end_of_input) begin
        if (bytes_held != 0) begin
          pad = BlockBytes - bytes_held;
          for (int i = 0; i < pad; i++) begin
            block_acc = {block_acc[31:0], (i == 0) ? PadMarker : 8'h00};
          end
          queue_block();
        end
        if (block_sent) queue_char(7'(DigitBase + pad));
        bytes_held = 0;
        block_sent = 1'b0;
      end
      if (awaited_chars.size() > first_new) begin
        awaited_chars[awaited_chars.size() - 1].run_last = 1'b1;
      end
    endfunction

    task report_mismatch(string what);
      $display("%0t MISMATCH %s", $time, what);
      mismatches++;
    endtask

    task check_char(out_item_t got);
      out_item_t want;
      if (awaited_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h", got.out_char));
        return;
      end
      want = awaited_chars.pop_front();
      if (got.out_char != want.out_char) begin
        report_mismatch($sformatf("char got 0x%02h want 0x%02h", got.out_char, want.out_char));
      end
      if (got.run_last != want.run_last) begin
        report_mismatch($sformatf("run_last got %0b want %0b", got.run_last, want.run_last));
      end
    endtask
  endclass

endpackage

>>> sim/tb_top.sv
// Top-level testbench for the five-byte to text encoder unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fbte_pkg::*;
  import text_char_check_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Percent chance per cycle that the sender idles or the receiver stalls.
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  // Idling phases: none, sender only, receiver only, both.
  int unsigned phase_idle[4]  = '{0, 67, 0, 29};
  int unsigned phase_stall[4] = '{0, 0, 67, 29};

  text_char_scoreboard char_board;

  five_byte_to_text_encoder_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (every request stalled out
  // on both sides, nine characters each).
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stall the receiver at random, redrawn every cycle.
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Sample both handshakes at the edge: predict from each accepted request
  // first, then check the character that left the block on the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) char_board.note_request(in_data);
      if (out_valid && !out_stall) char_board.check_char(out_data);
    end
  end

  // Offer one request: idle at random first, then hold valid and payload
  // until the block takes it. Valid stays high into the next request.
  task send_request(input in_item_t req);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task send_fields(input logic [7:0] data, input logic present, input logic last);
    in_item_t req;
    req.data_byte    = data;
    req.byte_present = present;
    req.end_of_input = last;
    send_request(req);
  endtask

  // Random streams with random bytes: mostly short, now and then long enough
  // for several blocks, closed either on the last byte or by a bare end.
  // Sprinkle empty requests (no byte, no end) as noise; they count as requests.
  task run_random_streams(input int unsigned quota);
    int unsigned sent;
    int unsigned len;
    bit closed;
    sent = 0;
    while (sent < quota) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
      closed = 1'b0;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0) begin
          send_fields(8'($urandom_range(255)), 1'b0, 1'b0);
          sent++;
        end
        closed = (i == len - 1) && ($urandom_range(1) == 1);
        send_fields(8'($urandom_range(255)), 1'b1, closed);
        sent++;
      end
      // A zero-length stream still gets its end: an empty stream makes nothing.
      if (!closed) begin
        send_fields(8'($urandom_range(255)), 1'b0, 1'b1);
        sent++;
      end
    end
  endtask

  initial begin
    char_board = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      if (ph == 0) begin
        // Bare end on an empty stream: no characters.
        send_fields(8'h3C, 1'b0, 1'b1);
        // Nothing at all: no byte, no end.
        send_fields(8'hA5, 1'b0, 1'b0);
        // All-zero block, then a bare end: pad digit zero.
        repeat (5) send_fields(8'h00, 1'b1, 1'b0);
        send_fields(8'h00, 1'b0, 1'b1);
        // All-ones block with the end riding on the last byte.
        repeat (4) send_fields(8'hFF, 1'b1, 1'b0);
        send_fields(8'hFF, 1'b1, 1'b1);
        // Partial blocks of one to four bytes, each padded out.
        send_fields(8'h55, 1'b1, 1'b1);
        send_fields(8'hAA, 1'b1, 1'b0);
        send_fields(8'h01, 1'b1, 1'b1);
        send_fields(8'h80, 1'b1, 1'b0);
        send_fields(8'h7F, 1'b1, 1'b0);
        send_fields(8'hFE, 1'b1, 1'b0);
        send_fields(8'h00, 1'b0, 1'b1);
        send_fields(8'h0F, 1'b1, 1'b0);
        send_fields(8'hF0, 1'b1, 1'b0);
        send_fields(8'h3C, 1'b1, 1'b0);
        send_fields(8'hC3, 1'b1, 1'b0);
        send_fields(8'hFF, 1'b0, 1'b1);
      end
      run_random_streams(100);
    end
    in_valid <= 1'b0;

    // Release the receiver and drain, then let the pipeline settle.
    stall_pct = 0;
    while (char_board.awaited_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (char_board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
sv/fbte_pkg.sv
sv/fbte_front.sv
sv/fbte_fifo.sv
sv/fbte_back.sv
sv/five_byte_to_text_encoder_unit.sv
sim/text_char_check_pkg.sv
sim/tb_top.sv
